FILE: hw/rtl/tfry_pkg.sv
`default_nettype none
package tfry_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t w0;
    word_t w1;
  } word_pair_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    word_t                  data;
  } cfg_t;

  localparam word_t PARITY = 64'h1BD1_1BDA_A9FC_1A22;

  localparam int unsigned ROT_TABLE [8] = '{16, 42, 12, 31, 16, 32, 24, 21};

  function automatic word_t rotl(input word_t v, input int unsigned amt);
    int unsigned b;
    b = amt % WORD_W;
    if (b == 0) begin
      return v;
    end
    return (v << b) | (v >> (WORD_W - b));
  endfunction

  function automatic word_t ks_word(input word_t k0, input word_t k1, input int unsigned idx);
    word_t r;
    case (idx % 3)
      0: r = k0;
      1: r = k1;
      default: r = PARITY ^ k0 ^ k1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tfry_count_if.sv
`default_nettype none
interface tfry_count_if;
  logic          valid;
  logic          ready;
  tfry_pkg::word_t count_low;
  tfry_pkg::word_t count_high;

  modport source (output valid, output count_low, output count_high, input ready);
  modport sink (input valid, input count_low, input count_high, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tfry_random_if.sv
`default_nettype none
interface tfry_random_if;
  logic          valid;
  logic          ready;
  tfry_pkg::word_t random_low;
  tfry_pkg::word_t random_high;

  modport source (output valid, output random_low, output random_high, input ready);
  modport sink (input valid, input random_low, input random_high, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tfry_round_cell.sv
`default_nettype none
module tfry_round_cell #(
  parameter int unsigned ROT_AMT = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tfry_pkg::word_pair_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tfry_pkg::word_pair_t      out_data
);

  tfry_pkg::word_pair_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next.w0 = in_data.w0 + in_data.w1;
    data_next.w1 = tfry_pkg::rotl(in_data.w1, ROT_AMT) ^ data_next.w0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tfry_inject_cell.sv
`default_nettype none
module tfry_inject_cell #(
  parameter int unsigned INJ = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tfry_pkg::cfg_t       cfg,
  input  wire tfry_pkg::word_t      key0,
  input  wire tfry_pkg::word_t      key1,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tfry_pkg::word_pair_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tfry_pkg::word_pair_t      out_data
);

  tfry_pkg::word_t key0_next;
  tfry_pkg::word_t key1_next;
  tfry_pkg::word_pair_t add;
  tfry_pkg::word_pair_t add_next;

  // The cell keeps its own key addends, refreshed on every key write.
  always_comb begin
    key0_next = key0;
    key1_next = key1;
    if (rst) begin
      key0_next = '0;
      key1_next = '0;
    end else if (cfg.we) begin
      case (cfg.index)
        tfry_pkg::REG_KEY_LOW:  key0_next = cfg.data;
        tfry_pkg::REG_KEY_HIGH: key1_next = cfg.data;
        default: ;
      endcase
    end
    add_next.w0 = tfry_pkg::ks_word(key0_next, key1_next, INJ);
    add_next.w1 = tfry_pkg::ks_word(key0_next, key1_next, INJ + 1)
                  + tfry_pkg::word_t'(INJ);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.we) begin
      add <= add_next;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.w0 <= in_data.w0 + add.w0;
      out_data.w1 <= in_data.w1 + add.w1;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/threefry_2x64_counter_rng.sv
`default_nettype none
// Threefry-2x64 counter-based generator built as a chain of cells, one cell per round and
// one per key injection, plus the initial key add. Each cell holds one transaction, so a new
// counter is taken every cycle when the output is not stalled; the result is registered in
// every cell of the chain in turn. Ready ripples back through the chain, so bubbles are
// filled while a finished result waits. Key writes go to index 0 (low word) and 1 (high
// word); other indexes are ignored. Write keys only while the chain is empty.
module threefry_2x64_counter_rng #(
  parameter int unsigned ROUND_COUNT = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              write_enable,
  input  wire logic [tfry_pkg::CFG_INDEX_W-1:0]  reg_index,
  input  wire logic [tfry_pkg::WORD_W-1:0]       write_data,
  tfry_count_if.sink                             counter,
  tfry_random_if.source                          result
);

  localparam int unsigned INJ_COUNT = ROUND_COUNT / 4;
  localparam int unsigned NSTAGE = 1 + ROUND_COUNT + INJ_COUNT;

  tfry_pkg::cfg_t       cfg;
  tfry_pkg::word_t      key0;
  tfry_pkg::word_t      key1;
  logic [NSTAGE-1:0]    stg_valid;
  logic [NSTAGE-1:0]    up_ready;
  logic [NSTAGE-1:0]    down_ready;
  tfry_pkg::word_pair_t stg_data [NSTAGE];
  tfry_pkg::word_pair_t in_data;

  assign cfg.we    = write_enable;
  assign cfg.index = reg_index;
  assign cfg.data  = write_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= '0;
      key1 <= '0;
    end else if (write_enable) begin
      case (reg_index)
        tfry_pkg::REG_KEY_LOW:  key0 <= write_data;
        tfry_pkg::REG_KEY_HIGH: key1 <= write_data;
        default: ;
      endcase
    end
  end

  assign in_data.w0    = counter.count_low;
  assign in_data.w1    = counter.count_high;
  assign counter.ready = up_ready[0];

  genvar j;
  generate
    for (j = 0; j < NSTAGE; j++) begin : g_ready
      if (j == NSTAGE - 1) begin : g_last
        assign down_ready[j] = result.ready;
      end else begin : g_mid
        assign down_ready[j] = up_ready[j+1];
      end
    end
  endgenerate

  tfry_inject_cell #(
    .INJ(0)
  ) u_key_add (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .key0      (key0),
    .key1      (key1),
    .in_valid  (counter.valid),
    .in_ready  (up_ready[0]),
    .in_data   (in_data),
    .out_valid (stg_valid[0]),
    .out_ready (down_ready[0]),
    .out_data  (stg_data[0])
  );

  genvar r;
  generate
    for (r = 0; r < ROUND_COUNT; r++) begin : g_round
      localparam int unsigned POS = 1 + r + r / 4;

      tfry_round_cell #(
        .ROT_AMT(tfry_pkg::ROT_TABLE[r % 8])
      ) u_round (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (stg_valid[POS-1]),
        .in_ready  (up_ready[POS]),
        .in_data   (stg_data[POS-1]),
        .out_valid (stg_valid[POS]),
        .out_ready (down_ready[POS]),
        .out_data  (stg_data[POS])
      );

      if (r % 4 == 3) begin : g_inject
        tfry_inject_cell #(
          .INJ(r / 4 + 1)
        ) u_inject (
          .clk       (clk),
          .rst       (rst),
          .cfg       (cfg),
          .key0      (key0),
          .key1      (key1),
          .in_valid  (stg_valid[POS]),
          .in_ready  (up_ready[POS+1]),
          .in_data   (stg_data[POS]),
          .out_valid (stg_valid[POS+1]),
          .out_ready (down_ready[POS+1]),
          .out_data  (stg_data[POS+1])
        );
      end
    end
  endgenerate

  assign result.valid       = stg_valid[NSTAGE-1];
  assign result.random_low  = stg_data[NSTAGE-1].w0;
  assign result.random_high = stg_data[NSTAGE-1].w1;

  // Reset empties every cell of the chain.
  a_reset_empty: assert property (@(posedge clk) rst |=> stg_valid == '0)
    else $error("chain not empty after reset");

  // A draining output lets the whole chain move.
  a_drain_moves: assert property (@(posedge clk) disable iff (rst)
    result.ready |-> counter.ready)
    else $error("chain stalled while output drains");

  // An empty first cell always takes a new transaction.
  a_head_free: assert property (@(posedge clk) disable iff (rst)
    !stg_valid[0] |-> counter.ready)
    else $error("empty first cell refused a transaction");

endmodule
`default_nettype wire

FILE: test/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROUNDS = 20;
  localparam int unsigned LATENCY = 1 + ROUNDS + ROUNDS / 4;
  localparam tfry_pkg::word_t KEY_PARITY = 64'h1BD1_1BDA_A9FC_1A22;
  localparam int unsigned ROTATION [8] = '{16, 42, 12, 31, 16, 32, 24, 21};
  localparam logic [tfry_pkg::CFG_INDEX_W-1:0] REG_SPARE_LOW = 2'd2;
  localparam logic [tfry_pkg::CFG_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;
  localparam tfry_pkg::word_t ALL_ONES = '1;
  localparam tfry_pkg::word_t MSB_ONLY = tfry_pkg::word_t'(1) << (tfry_pkg::WORD_W - 1);
  localparam tfry_pkg::word_t CHECKER_A = 64'h5555_5555_5555_5555;
  localparam tfry_pkg::word_t CHECKER_B = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk;
  logic rst;
  logic write_enable;
  logic [tfry_pkg::CFG_INDEX_W-1:0] reg_index;
  tfry_pkg::word_t write_data;

  tfry_count_if counter_bus();
  tfry_random_if result_bus();

  threefry_2x64_counter_rng #(
    .ROUND_COUNT(ROUNDS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data),
    .counter(counter_bus),
    .result(result_bus)
  );

  tfry_pkg::word_pair_t expected_random [$];
  tfry_pkg::word_t key_low_copy;
  tfry_pkg::word_t key_high_copy;
  tfry_pkg::word_t next_index = '0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tfry_pkg::word_pair_t threefry_block(
      input tfry_pkg::word_t k0, input tfry_pkg::word_t k1,
      input tfry_pkg::word_t c0, input tfry_pkg::word_t c1);
    tfry_pkg::word_t sched [3];
    tfry_pkg::word_t x0;
    tfry_pkg::word_t x1;
    int unsigned amt;
    int unsigned inj;
    tfry_pkg::word_pair_t out;
    sched[0] = k0;
    sched[1] = k1;
    sched[2] = KEY_PARITY ^ k0 ^ k1;
    x0 = c0 + k0;
    x1 = c1 + k1;
    for (int unsigned rnd = 0; rnd < ROUNDS; rnd++) begin
      amt = ROTATION[rnd % 8];
      x0 = x0 + x1;
      x1 = (x1 << amt) | (x1 >> (tfry_pkg::WORD_W - amt));
      x1 = x1 ^ x0;
      if (rnd % 4 == 3) begin
        inj = rnd / 4 + 1;
        x0 = x0 + sched[inj % 3];
        x1 = x1 + sched[(inj + 1) % 3] + tfry_pkg::word_t'(inj);
      end
    end
    out.w0 = x0;
    out.w1 = x1;
    return out;
  endfunction

  function automatic tfry_pkg::word_t random_word();
    tfry_pkg::word_t v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = ALL_ONES;
      2: v = tfry_pkg::word_t'(1) << $urandom_range(tfry_pkg::WORD_W - 1);
      3: v = tfry_pkg::word_t'($urandom_range(15));
      4: v = ALL_ONES - tfry_pkg::word_t'($urandom_range(15));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function tfry_pkg::word_pair_t random_counter();
    tfry_pkg::word_pair_t c;
    if ($urandom_range(3) == 0) begin
      c.w0 = next_index;
      c.w1 = '0;
      next_index = next_index + 1;
    end else begin
      c.w0 = random_word();
      c.w1 = random_word();
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input tfry_pkg::word_pair_t want,
                                 input tfry_pkg::word_pair_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected low %h high %h, got low %h high %h",
               $realtime, what, want.w0, want.w1, got.w0, got.w1);
    end
  endtask

  always @(posedge clk) begin : check_results
    tfry_pkg::word_pair_t want;
    tfry_pkg::word_pair_t got;
    if (rst) begin
      key_low_copy = '0;
      key_high_copy = '0;
    end else begin
      got.w0 = result_bus.random_low;
      got.w1 = result_bus.random_high;
      if (result_bus.valid && result_bus.ready) begin
        if (expected_random.size() == 0) begin
          report_mismatch("unexpected result transaction", '0, got);
        end else begin
          want = expected_random.pop_front();
          if (want.w0 != got.w0 || want.w1 != got.w1) begin
            report_mismatch("random word mismatch", want, got);
          end
        end
      end
      if (counter_bus.valid && counter_bus.ready) begin
        expected_random = {expected_random,
                           threefry_block(key_low_copy, key_high_copy,
                                          counter_bus.count_low,
                                          counter_bus.count_high)};
      end
      if (write_enable) begin
        if (reg_index == tfry_pkg::REG_KEY_LOW) begin
          key_low_copy = write_data;
        end else if (reg_index == tfry_pkg::REG_KEY_HIGH) begin
          key_high_copy = write_data;
        end
      end
    end
  end

  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_count(input tfry_pkg::word_pair_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      counter_bus.valid <= 1'b0;
      @(negedge clk);
    end
    counter_bus.valid <= 1'b1;
    counter_bus.count_low <= c.w0;
    counter_bus.count_high <= c.w1;
    do begin
      @(posedge clk);
    end while (!counter_bus.ready);
  endtask

  task automatic send_pair(input tfry_pkg::word_t lo, input tfry_pkg::word_t hi);
    tfry_pkg::word_pair_t c;
    c.w0 = lo;
    c.w1 = hi;
    send_count(c);
  endtask

  task automatic write_key(input logic [tfry_pkg::CFG_INDEX_W-1:0] idx,
                           input tfry_pkg::word_t value);
    @(negedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= value;
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic settle_pipeline();
    @(negedge clk);
    counter_bus.valid <= 1'b0;
    while (expected_random.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic test_reset_keys();
    send_pair('0, '0);
    send_pair(ALL_ONES, ALL_ONES);
    send_pair(tfry_pkg::word_t'(1), '0);
    send_pair('0, tfry_pkg::word_t'(1));
    send_pair(MSB_ONLY, MSB_ONLY);
    send_pair(CHECKER_A, CHECKER_B);
    settle_pipeline();
  endtask

  task automatic test_key_extremes();
    write_key(tfry_pkg::REG_KEY_LOW, ALL_ONES);
    write_key(tfry_pkg::REG_KEY_HIGH, ALL_ONES);
    send_pair(ALL_ONES, ALL_ONES);
    send_pair(tfry_pkg::word_t'(1), tfry_pkg::word_t'(1));
    send_pair('0, '0);
    settle_pipeline();
    write_key(tfry_pkg::REG_KEY_LOW, '0);
    write_key(tfry_pkg::REG_KEY_HIGH, ALL_ONES);
    send_pair(ALL_ONES, '0);
    send_pair(CHECKER_B, CHECKER_A);
    send_pair(MSB_ONLY, ALL_ONES);
    settle_pipeline();
    write_key(tfry_pkg::REG_KEY_LOW, KEY_PARITY);
    write_key(tfry_pkg::REG_KEY_HIGH, '0);
    send_pair('0, '0);
    send_pair(ALL_ONES, tfry_pkg::word_t'(1));
    settle_pipeline();
  endtask

  task automatic test_ignored_index();
    write_key(tfry_pkg::REG_KEY_LOW, {$urandom, $urandom});
    write_key(tfry_pkg::REG_KEY_HIGH, {$urandom, $urandom});
    write_key(REG_SPARE_LOW, {$urandom, $urandom});
    write_key(REG_SPARE_HIGH, ALL_ONES);
    send_pair('0, '0);
    send_pair(ALL_ONES, ALL_ONES);
    send_pair({$urandom, $urandom}, {$urandom, $urandom});
    settle_pipeline();
    write_key(REG_SPARE_HIGH, '0);
    send_pair(tfry_pkg::word_t'(7), '0);
    settle_pipeline();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 80;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 80;
        end
        default: begin
          send_idle_pct = 11;
          recv_stall_pct = 11;
        end
      endcase
      write_key(tfry_pkg::REG_KEY_LOW, random_word());
      write_key(tfry_pkg::REG_KEY_HIGH, random_word());
      repeat (100) send_count(random_counter());
      settle_pipeline();
    end
  endtask

  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_key(tfry_pkg::REG_KEY_LOW, {$urandom, $urandom});
    write_key(tfry_pkg::REG_KEY_HIGH, {$urandom, $urandom});
    hold_left = 400;
    repeat (60) send_count(random_counter());
    settle_pipeline();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    write_enable = 1'b0;
    reg_index = tfry_pkg::REG_KEY_LOW;
    write_data = '0;
    counter_bus.valid = 1'b0;
    counter_bus.count_low = '0;
    counter_bus.count_high = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_keys();
    test_key_extremes();
    test_ignored_index();
    test_random_traffic();
    test_back_pressure();
    settle_pipeline();
    if (mismatch_count == 0 && expected_random.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
